>>> rtl/tlpw_pkg.sv
// shared constants, codes and store access types for the page table walker
package tlpw_pkg;

  localparam int DIR_AW   = 10;
  localparam int TAB_AW   = 20;
  localparam int DIR_W    = 22;
  localparam int TAB_W    = 21;
  localparam int ADDR_W   = 32;
  localparam int SPAN_W   = 33;

  localparam int PRESENT_BIT = 20;
  localparam int LARGE_BIT   = 21;

  localparam logic [SPAN_W-1:0] ADDR_SPACE = 33'h1_0000_0000;
  localparam logic [SPAN_W-1:0] SZ_4K      = 33'h0_0000_1000;
  localparam logic [SPAN_W-1:0] SZ_4M      = 33'h0_0040_0000;

  typedef enum logic [2:0] {
    OP_WR_DIR = 3'd0,
    OP_WR_TAB = 3'd1,
    OP_XLATE  = 3'd2,
    OP_SIZE   = 3'd3,
    OP_RMAP   = 3'd4,
    OP_RUNMAP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PS_NONE = 2'd0,
    PS_4K   = 2'd1,
    PS_4M   = 2'd2
  } psize_t;

  typedef struct packed {
    logic              dir_we;
    logic [DIR_AW-1:0] dir_waddr;
    logic [DIR_W-1:0]  dir_wdata;
    logic              dir_re;
    logic [DIR_AW-1:0] dir_raddr;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [TAB_W-1:0]  tab_wdata;
    logic              tab_re;
    logic [TAB_AW-1:0] tab_raddr;
  } store_req_t;

endpackage

>>> rtl/two_level_page_table_walker_unit.sv
// two-level x86 style page table walker: entry writes, translation, page size queries and range checks
//
// After reset the block clears its page directory and all page tables, one
// table entry (and one directory entry) a cycle; busy is high meanwhile. A
// command is taken when start is high and busy is low. An entry write
// answers in the next cycle, a translation or page size query after one
// directory read, then one table read when a 4K table is used. A range
// check reads the synchronous memories with registered reads one entry a
// cycle. The mapped check reads each directory entry and each 4K table
// entry it visits once. The unmapped check rereads the directory entry
// before each table entry, but it only steps in 4K inside a partly covered
// 4M block and needs a single directory read per whole 4M block. The answer
// is shown for one cycle with done; it cannot be held off.
module two_level_page_table_walker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [31:0] vaddr,
  input  logic [31:0] range_length,
  input  logic [31:0] entry_value,
  output logic        done,
  output logic [31:0] phys_addr,
  output logic [1:0]  page_size,
  output logic        range_ok
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DIR   = 4'b0100,
    S_TAB   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [2:0]                      op, op_next;
  logic [tlpw_pkg::SPAN_W-1:0]     a, a_next;
  logic [tlpw_pkg::SPAN_W-1:0]     end_addr, end_addr_next;
  logic [tlpw_pkg::TAB_AW-1:0]     clr, clr_next;
  logic                            done_next;
  logic [31:0]                     phys_addr_next;
  logic [1:0]                      page_size_next;
  logic                            range_ok_next;

  tlpw_pkg::store_req_t            req;
  logic [tlpw_pkg::DIR_W-1:0]      dir_rdata;
  logic [tlpw_pkg::TAB_W-1:0]      tab_rdata;

  logic [tlpw_pkg::SPAN_W-1:0]     sum;
  logic [tlpw_pkg::SPAN_W-1:0]     blk_next;
  logic [tlpw_pkg::SPAN_W-1:0]     pg_next;
  logic [tlpw_pkg::SPAN_W-1:0]     remain;
  logic                            d_pres, d_large, t_pres;

  tlpw_store u_store (
    .clk       (clk),
    .req       (req),
    .dir_rdata (dir_rdata),
    .tab_rdata (tab_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign sum      = {1'b0, vaddr} + {1'b0, range_length};
  assign blk_next = {a[32:22] + 11'd1, 22'd0};
  assign pg_next  = a + tlpw_pkg::SZ_4K;
  assign remain   = end_addr - a;
  assign d_pres   = dir_rdata[tlpw_pkg::PRESENT_BIT];
  assign d_large  = dir_rdata[tlpw_pkg::LARGE_BIT];
  assign t_pres   = tab_rdata[tlpw_pkg::PRESENT_BIT];

  always_comb begin
    state_next     = state;
    op_next        = op;
    a_next         = a;
    end_addr_next  = end_addr;
    clr_next       = clr;
    done_next      = 1'b0;
    phys_addr_next = phys_addr;
    page_size_next = page_size;
    range_ok_next  = range_ok;
    req            = '0;

    unique case (state)
      S_CLEAR: begin
        req.dir_we    = 1'b1;
        req.dir_waddr = clr[tlpw_pkg::DIR_AW-1:0];
        req.tab_we    = 1'b1;
        req.tab_waddr = clr;
        clr_next      = clr + 20'd1;
        if (&clr) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_next        = opcode;
          a_next         = {1'b0, vaddr};
          end_addr_next  = sum;
          phys_addr_next = '0;
          page_size_next = tlpw_pkg::PS_NONE;
          range_ok_next  = 1'b0;
          req.dir_raddr  = vaddr[31:22];
          case (opcode)
            tlpw_pkg::OP_WR_DIR: begin
              req.dir_we    = 1'b1;
              req.dir_waddr = vaddr[31:22];
              req.dir_wdata = {entry_value[7], entry_value[0], entry_value[31:12]};
              done_next     = 1'b1;
            end
            tlpw_pkg::OP_WR_TAB: begin
              req.tab_we    = 1'b1;
              req.tab_waddr = vaddr[31:12];
              req.tab_wdata = {entry_value[0], entry_value[31:12]};
              done_next     = 1'b1;
            end
            tlpw_pkg::OP_XLATE, tlpw_pkg::OP_SIZE: begin
              req.dir_re = 1'b1;
              state_next = S_DIR;
            end
            tlpw_pkg::OP_RMAP, tlpw_pkg::OP_RUNMAP: begin
              if ((|vaddr[11:0]) || (|range_length[11:0]) ||
                  (sum > tlpw_pkg::ADDR_SPACE)) begin
                done_next = 1'b1;
              end else if (range_length == 32'd0) begin
                range_ok_next = 1'b1;
                done_next     = 1'b1;
              end else begin
                req.dir_re = 1'b1;
                state_next = S_DIR;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_DIR: begin
        req.tab_raddr = a[31:12];
        case (op)
          tlpw_pkg::OP_XLATE: begin
            if (!d_pres) begin
              phys_addr_next = '1;
              done_next      = 1'b1;
              state_next     = S_IDLE;
            end else if (d_large) begin
              phys_addr_next = {dir_rdata[19:10], a[21:0]};
              done_next      = 1'b1;
              state_next     = S_IDLE;
            end else begin
              req.tab_re = 1'b1;
              state_next = S_TAB;
            end
          end
          tlpw_pkg::OP_SIZE: begin
            if (!d_pres) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (d_large) begin
              page_size_next = tlpw_pkg::PS_4M;
              done_next      = 1'b1;
              state_next     = S_IDLE;
            end else begin
              req.tab_re = 1'b1;
              state_next = S_TAB;
            end
          end
          tlpw_pkg::OP_RMAP: begin
            if (!d_pres) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (d_large) begin
              a_next        = blk_next;
              req.dir_raddr = blk_next[31:22];
              if (blk_next >= end_addr) begin
                range_ok_next = 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
              end else begin
                req.dir_re = 1'b1;
              end
            end else begin
              req.tab_re = 1'b1;
              state_next = S_TAB;
            end
          end
          tlpw_pkg::OP_RUNMAP: begin
            if (((a[21:0] == 22'd0) && (remain >= tlpw_pkg::SZ_4M)) || !d_pres) begin
              if (d_pres) begin
                done_next  = 1'b1;
                state_next = S_IDLE;
              end else begin
                a_next        = blk_next;
                req.dir_raddr = blk_next[31:22];
                if (blk_next >= end_addr) begin
                  range_ok_next = 1'b1;
                  done_next     = 1'b1;
                  state_next    = S_IDLE;
                end else begin
                  req.dir_re = 1'b1;
                end
              end
            end else if (d_large) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              req.tab_re = 1'b1;
              state_next = S_TAB;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_TAB: begin
        req.dir_raddr = pg_next[31:22];
        req.tab_raddr = pg_next[31:12];
        case (op)
          tlpw_pkg::OP_XLATE: begin
            phys_addr_next = t_pres ? {tab_rdata[19:0], a[11:0]} : '1;
            done_next      = 1'b1;
            state_next     = S_IDLE;
          end
          tlpw_pkg::OP_SIZE: begin
            page_size_next = t_pres ? tlpw_pkg::PS_4K : tlpw_pkg::PS_NONE;
            done_next      = 1'b1;
            state_next     = S_IDLE;
          end
          tlpw_pkg::OP_RMAP: begin
            a_next = pg_next;
            if (!t_pres) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (pg_next >= end_addr) begin
              range_ok_next = 1'b1;
              done_next     = 1'b1;
              state_next    = S_IDLE;
            end else if (&a[21:12]) begin
              req.dir_re = 1'b1;
              state_next = S_DIR;
            end else begin
              req.tab_re = 1'b1;
            end
          end
          tlpw_pkg::OP_RUNMAP: begin
            a_next = pg_next;
            if (t_pres) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (pg_next >= end_addr) begin
              range_ok_next = 1'b1;
              done_next     = 1'b1;
              state_next    = S_IDLE;
            end else begin
              req.dir_re = 1'b1;
              state_next = S_DIR;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    a         <= a_next;
    end_addr  <= end_addr_next;
    phys_addr <= phys_addr_next;
    page_size <= page_size_next;
    range_ok  <= range_ok_next;
  end

endmodule

>>> rtl/tlpw_store.sv
// directory and page table memories, one write and one registered read each
module tlpw_store (
  input  logic                           clk,
  input  tlpw_pkg::store_req_t           req,
  output logic [tlpw_pkg::DIR_W-1:0]     dir_rdata,
  output logic [tlpw_pkg::TAB_W-1:0]     tab_rdata
);

  logic [tlpw_pkg::DIR_W-1:0] dir_mem [2**tlpw_pkg::DIR_AW];
  logic [tlpw_pkg::TAB_W-1:0] tab_mem [2**tlpw_pkg::TAB_AW];

  always_ff @(posedge clk) begin
    if (req.dir_we) begin
      dir_mem[req.dir_waddr] <= req.dir_wdata;
    end
    if (req.dir_re) begin
      dir_rdata <= dir_mem[req.dir_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.tab_we) begin
      tab_mem[req.tab_waddr] <= req.tab_wdata;
    end
    if (req.tab_re) begin
      tab_rdata <= tab_mem[req.tab_raddr];
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the two-level page table walker unit
`timescale 1ns / 1ps

module tb_top;

  localparam longint CYCLE_LIMIT = 64'd60_000_000;
  localparam int     N_RANDOM    = 1200;

  typedef struct {
    logic [31:0] pa;
    logic [1:0]  ps;
    logic        ok;
  } walk_result_t;

  class walk_scoreboard;
    logic [21:0]  dir_mem [1024];
    logic [20:0]  tab_mem [int];
    walk_result_t pending [$];

    function new();
      foreach (dir_mem[i]) dir_mem[i] = '0;
    endfunction

    function logic [21:0] dir_at(longint unsigned a);
      return dir_mem[(a >> 22) & 64'h3ff];
    endfunction

    function logic [20:0] tab_at(longint unsigned a);
      int idx;
      idx = int'((a >> 12) & 64'hfffff);
      return tab_mem.exists(idx) ? tab_mem[idx] : 21'd0;
    endfunction

    function logic [31:0] xlate(logic [31:0] a);
      logic [21:0] d;
      logic [20:0] t;
      d = dir_at(a);
      if (!d[tlpw_pkg::PRESENT_BIT]) return 32'hffff_ffff;
      if (d[tlpw_pkg::LARGE_BIT]) return {d[19:10], a[21:0]};
      t = tab_at(a);
      if (!t[tlpw_pkg::PRESENT_BIT]) return 32'hffff_ffff;
      return {t[19:0], a[11:0]};
    endfunction

    function logic [1:0] size_of(logic [31:0] a);
      logic [21:0] d;
      logic [20:0] t;
      d = dir_at(a);
      if (!d[tlpw_pkg::PRESENT_BIT]) return tlpw_pkg::PS_NONE;
      if (d[tlpw_pkg::LARGE_BIT]) return tlpw_pkg::PS_4M;
      t = tab_at(a);
      return t[tlpw_pkg::PRESENT_BIT] ? tlpw_pkg::PS_4K : tlpw_pkg::PS_NONE;
    endfunction

    function bit all_mapped(longint unsigned s, longint unsigned e);
      longint unsigned a;
      logic [21:0] d;
      logic [20:0] t;
      int ent;
      a = s;
      while (a < e) begin
        d = dir_at(a);
        if (!d[tlpw_pkg::PRESENT_BIT]) return 0;
        if (d[tlpw_pkg::LARGE_BIT]) begin
          a = (a + 64'h40_0000) & ~64'h3f_ffff;
          continue;
        end
        ent = int'((a >> 12) & 64'h3ff);
        do begin
          t = tab_at(a);
          if (!t[tlpw_pkg::PRESENT_BIT]) return 0;
          a += 64'h1000;
          ent++;
        end while (a < e && ent < 1024);
      end
      return 1;
    endfunction

    function bit all_unmapped(longint unsigned s, longint unsigned e);
      longint unsigned a;
      logic [21:0] d;
      logic [20:0] t;
      a = s;
      while (a < e) begin
        d = dir_at(a);
        if ((a & 64'h3f_ffff) == 0 && e - a >= 64'h40_0000) begin
          if (d[tlpw_pkg::PRESENT_BIT]) return 0;
          a += 64'h40_0000;
        end else if (d[tlpw_pkg::PRESENT_BIT]) begin
          if (d[tlpw_pkg::LARGE_BIT]) return 0;
          t = tab_at(a);
          if (t[tlpw_pkg::PRESENT_BIT]) return 0;
          a += 64'h1000;
        end else begin
          a = ((a >> 22) + 1) << 22;
        end
      end
      return 1;
    endfunction

    function void note(logic [2:0] op, logic [31:0] va, logic [31:0] len,
                       logic [31:0] val);
      walk_result_t r;
      longint unsigned e;
      r = '{32'd0, 2'd0, 1'b0};
      e = longint'(va) + longint'(len);
      case (op)
        tlpw_pkg::OP_WR_DIR: dir_mem[va[31:22]] = {val[7], val[0], val[31:12]};
        tlpw_pkg::OP_WR_TAB: tab_mem[int'(va[31:12])] = {val[0], val[31:12]};
        tlpw_pkg::OP_XLATE:  r.pa = xlate(va);
        tlpw_pkg::OP_SIZE:   r.ps = size_of(va);
        tlpw_pkg::OP_RMAP, tlpw_pkg::OP_RUNMAP: begin
          if (va[11:0] != 0 || len[11:0] != 0 || e > 64'h1_0000_0000) r.ok = 0;
          else if (op == tlpw_pkg::OP_RMAP) r.ok = all_mapped(va, e);
          else r.ok = all_unmapped(va, e);
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function string check(logic [31:0] pa, logic [1:0] ps, logic ok);
      walk_result_t x;
      if (pending.size() == 0) return "result with nothing expected";
      x = pending.pop_front();
      if (pa !== x.pa || ps !== x.ps || ok !== x.ok)
        return $sformatf("got pa=%h ps=%0d ok=%b, want pa=%h ps=%0d ok=%b",
                         pa, ps, ok, x.pa, x.ps, x.ok);
      return "";
    endfunction
  endclass

  logic        clk, rst, start, busy, done, range_ok;
  logic [2:0]  opcode;
  logic [31:0] vaddr, range_length, entry_value, phys_addr;
  logic [1:0]  page_size;

  walk_scoreboard sb;
  int     errors;
  longint cycles;

  two_level_page_table_walker_unit dut (
    .clk, .rst, .start, .busy, .opcode, .vaddr, .range_length,
    .entry_value, .done, .phys_addr, .page_size, .range_ok
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic issue(logic [2:0] op, logic [31:0] va, logic [31:0] len,
                       logic [31:0] val);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    opcode <= op;
    vaddr <= va;
    range_length <= len;
    entry_value <= val;
    do @(posedge clk); while (busy);
    sb.note(op, va, len, val);
  endtask

  function automatic logic [9:0] pick_dir();
    case ($urandom_range(0, 7))
      0, 1, 2: return 10'($urandom_range(0, 3));
      3:       return 10'h3ff;
      4:       return 10'h3fe;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_ent();
    return ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'($urandom_range(1, 3)) << 22;
      2:       return {10'($urandom_range(0, 1023)), 22'd0} | ($urandom & 32'h003f_f000);
      default: return 32'($urandom_range(0, 40)) << 12;
    endcase
  endfunction

  always @(posedge clk) begin
    string msg;
    if (!rst && done) begin
      msg = sb.check(phys_addr, page_size, range_ok);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [2:0]  op;
    logic [31:0] va, val;
    sb = new();
    errors = 0;
    cycles = 0;
    rst = 1;
    start = 0;
    opcode = '0;
    vaddr = '0;
    range_length = '0;
    entry_value = '0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: 4K table under slot 0, large page at slot 1, empty table at slot 2
    issue(tlpw_pkg::OP_WR_DIR, 32'h0000_0000, 0, 32'h0012_3001);
    issue(tlpw_pkg::OP_WR_TAB, 32'h0000_0000, 0, 32'hffff_f001);
    issue(tlpw_pkg::OP_WR_TAB, 32'h0000_1000, 0, 32'h0abc_d0fe);
    issue(tlpw_pkg::OP_WR_DIR, 32'h0040_0000, 0, 32'hffff_f081);
    issue(tlpw_pkg::OP_WR_DIR, 32'h0080_0000, 0, 32'h0000_0001);
    issue(tlpw_pkg::OP_WR_DIR, 32'hffc0_0000, 0, 32'hffff_fffe);
    issue(tlpw_pkg::OP_XLATE,  32'h0000_0fff, 0, 0);
    issue(tlpw_pkg::OP_XLATE,  32'h0000_1234, 0, 0);
    issue(tlpw_pkg::OP_XLATE,  32'h007f_ffff, 0, 0);
    issue(tlpw_pkg::OP_XLATE,  32'hffff_ffff, 0, 0);
    issue(tlpw_pkg::OP_SIZE,   32'h0000_0000, 0, 0);
    issue(tlpw_pkg::OP_SIZE,   32'h0040_0000, 0, 0);
    issue(tlpw_pkg::OP_SIZE,   32'h0000_1000, 0, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0000_0000, 32'h0000_1000, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0000_0000, 32'h0000_2000, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0040_0000, 32'h0040_0000, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0000_0800, 32'h0000_1000, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0000_0000, 32'h0000_1001, 0);
    issue(tlpw_pkg::OP_RMAP,   32'h0000_0000, 32'h0000_0000, 0);
    issue(tlpw_pkg::OP_RUNMAP, 32'h0000_0000, 32'h0000_0000, 0);
    issue(tlpw_pkg::OP_RUNMAP, 32'h0080_0000, 32'h0040_0000, 0);
    issue(tlpw_pkg::OP_RUNMAP, 32'h0080_0000, 32'h0000_3000, 0);
    issue(tlpw_pkg::OP_RUNMAP, 32'hffff_f000, 32'h0000_2000, 0);
    issue(tlpw_pkg::OP_RUNMAP, 32'h0100_0000, 32'hfec0_0000, 0);
    issue(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(3'd7, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);

    for (int i = 0; i < N_RANDOM; i++) begin
      va = {pick_dir(), pick_ent(), 12'd0};
      if ($urandom_range(0, 7) == 0) va = $urandom;
      val = $urandom;
      case ($urandom_range(0, 19))
        0, 1, 2:    op = tlpw_pkg::OP_WR_DIR;
        3, 4, 5, 6: op = tlpw_pkg::OP_WR_TAB;
        7, 8, 9:    op = tlpw_pkg::OP_XLATE;
        10, 11:     op = tlpw_pkg::OP_SIZE;
        12, 13, 14: op = tlpw_pkg::OP_RMAP;
        15, 16, 17: op = tlpw_pkg::OP_RUNMAP;
        default:    op = 3'($urandom);
      endcase
      if (op == tlpw_pkg::OP_WR_DIR && $urandom_range(0, 2) != 0)
        val[7] = $urandom_range(0, 3) == 0;
      if ((op == tlpw_pkg::OP_XLATE || op == tlpw_pkg::OP_SIZE) && $urandom_range(0, 1))
        va[11:0] = 12'($urandom);
      issue(op, va, pick_len(), val);
    end
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tlpw_pkg.sv
rtl/tlpw_store.sv
rtl/two_level_page_table_walker_unit.sv
tb/sv/tb_top.sv
